[rtl/core/rdq_pkg.sv]
// Shared constants and types for the record deque with search.
`timescale 1ns / 1ps

package rdq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int ID_W = 32;
	localparam int PAY_W = 64;
	localparam int REC_W = ID_W + PAY_W;

	localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] OFF_PREV = IDX_W'(CAPACITY - 1);
	localparam logic [IDX_W-1:0] OFF_NEXT = IDX_W'(1);

	localparam logic [2:0] FN_PUSH_BACK = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_POP_BACK = 3'd2;
	localparam logic [2:0] FN_POP_FRONT = 3'd3;
	localparam logic [2:0] FN_READ_POS = 3'd4;
	localparam logic [2:0] FN_FIND_ID = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

endpackage

[rtl/core/rdq_ram.sv]
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module rdq_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/record_deque_with_search.sv]
// Top level of the record deque with push, pop, read by position and find by id.
`timescale 1ns / 1ps

//  Channel   Ports                                              Handshake
//  request   func, position, record_id, record_payload          start && !busy
//  result    ok, out_id, out_payload, entry_count, is_empty     done (one cycle)
//
// Pushes, pops and failed requests put their result out in the cycle after the
// transaction and leave busy low. A read by position goes through ST_READ, since
// the record store has a registered read port. A find scans the ring from the
// head through the one ring-index adder and id comparator, one record a cycle,
// and ends on a match or after the last stored record. Reset empties the queue;
// the record store itself is not cleared. The receiver cannot stall a result.

module record_deque_with_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 func,
	input  logic signed [31:0]         position,
	input  logic signed [31:0]         record_id,
	input  logic [63:0]                record_payload,
	output logic                       done,
	output logic                       ok,
	output logic signed [31:0]         out_id,
	output logic [63:0]                out_payload,
	output logic [4:0]                 entry_count,
	output logic                       is_empty
);

	rdq_pkg::state_t state_q, state_d;

	logic [rdq_pkg::IDX_W-1:0] head_q, head_d;
	logic [rdq_pkg::CNT_W-1:0] count_q, count_d;
	logic [rdq_pkg::CNT_W-1:0] k_q, k_d;
	logic                      chk_q, chk_d;
	logic [rdq_pkg::ID_W-1:0]  key_q;

	logic done_q, ok_q;
	logic [rdq_pkg::ID_W-1:0]  id_q;
	logic [rdq_pkg::PAY_W-1:0] pay_q;

	logic accept;
	logic full, empty;
	logic in_range;
	logic [31:0] pos_u, pos_m1;

	// Shared ring-index unit: (head + offset) modulo the capacity.
	logic [rdq_pkg::IDX_W-1:0] off;
	logic [rdq_pkg::SUM_W-1:0] ring_sum, ring_wrap;
	logic [rdq_pkg::IDX_W-1:0] ring_idx;

	logic we;
	logic [rdq_pkg::REC_W-1:0] wr_word, rd_word;
	logic [rdq_pkg::ID_W-1:0]  rd_id;
	logic [rdq_pkg::PAY_W-1:0] rd_pay;
	logic match;

	logic res_set, res_ok, res_hit;
	logic [rdq_pkg::CNT_W+4:0] count_x;

	assign busy = (state_q != rdq_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign full = (count_q == rdq_pkg::CNT_FULL);
	assign empty = (count_q == '0);

	assign pos_u = position;
	assign pos_m1 = pos_u - 32'd1;
	assign in_range = (pos_u != 32'd0) && (pos_u <= 32'(count_q));

	assign ring_sum = {1'b0, head_q} + {1'b0, off};
	assign ring_wrap = ring_sum - rdq_pkg::CAP_SUM;
	assign ring_idx = (ring_sum >= rdq_pkg::CAP_SUM) ? ring_wrap[rdq_pkg::IDX_W-1:0]
		: ring_sum[rdq_pkg::IDX_W-1:0];

	assign wr_word = {record_id, record_payload};
	assign rd_id = rd_word[rdq_pkg::PAY_W +: rdq_pkg::ID_W];
	assign rd_pay = rd_word[rdq_pkg::PAY_W-1:0];
	assign match = chk_q && (rd_id == key_q);

	rdq_ram #(
		.WIDTH(rdq_pkg::REC_W),
		.DEPTH(rdq_pkg::CAPACITY)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(ring_idx),
		.wdata(wr_word),
		.raddr(ring_idx),
		.rdata(rd_word)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rdq_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == rdq_pkg::FN_READ_POS && in_range) begin
						state_d = rdq_pkg::ST_READ;
					end else if (func == rdq_pkg::FN_FIND_ID && !empty) begin
						state_d = rdq_pkg::ST_SCAN;
					end
				end
			end
			rdq_pkg::ST_READ: begin
				state_d = rdq_pkg::ST_IDLE;
			end
			rdq_pkg::ST_SCAN: begin
				if (match || (k_q == count_q)) begin
					state_d = rdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdq_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath control.
	always_comb begin
		off = k_q[rdq_pkg::IDX_W-1:0];
		we = 1'b0;
		head_d = head_q;
		count_d = count_q;
		k_d = k_q;
		chk_d = 1'b0;
		res_set = 1'b0;
		res_ok = 1'b0;
		res_hit = 1'b0;
		unique case (state_q)
			rdq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (func)
						rdq_pkg::FN_PUSH_BACK: begin
							off = count_q[rdq_pkg::IDX_W-1:0];
							res_set = 1'b1;
							if (!full) begin
								we = 1'b1;
								count_d = count_q + 1'b1;
								res_ok = 1'b1;
							end
						end
						rdq_pkg::FN_PUSH_FRONT: begin
							off = rdq_pkg::OFF_PREV;
							res_set = 1'b1;
							if (!full) begin
								we = 1'b1;
								head_d = ring_idx;
								count_d = count_q + 1'b1;
								res_ok = 1'b1;
							end
						end
						rdq_pkg::FN_POP_BACK: begin
							res_set = 1'b1;
							if (!empty) begin
								count_d = count_q - 1'b1;
								res_ok = 1'b1;
							end
						end
						rdq_pkg::FN_POP_FRONT: begin
							off = rdq_pkg::OFF_NEXT;
							res_set = 1'b1;
							if (!empty) begin
								head_d = ring_idx;
								count_d = count_q - 1'b1;
								res_ok = 1'b1;
							end
						end
						rdq_pkg::FN_READ_POS: begin
							off = pos_m1[rdq_pkg::IDX_W-1:0];
							res_set = !in_range;
						end
						rdq_pkg::FN_FIND_ID: begin
							k_d = '0;
							res_set = empty;
						end
						default: begin
							res_set = 1'b1;
						end
					endcase
				end
			end
			rdq_pkg::ST_READ: begin
				res_set = 1'b1;
				res_ok = 1'b1;
				res_hit = 1'b1;
			end
			rdq_pkg::ST_SCAN: begin
				if (match) begin
					res_set = 1'b1;
					res_ok = 1'b1;
					res_hit = 1'b1;
				end else if (k_q == count_q) begin
					res_set = 1'b1;
				end else begin
					// The read issued here is compared in the next cycle.
					k_d = k_q + 1'b1;
					chk_d = 1'b1;
				end
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdq_pkg::ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			k_q <= '0;
			chk_q <= 1'b0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			k_q <= k_d;
			chk_q <= chk_d;
			done_q <= res_set;
			if (res_set) begin
				ok_q <= res_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= record_id;
		end
		if (res_set) begin
			id_q <= res_hit ? rd_id : '0;
			pay_q <= res_hit ? rd_pay : '0;
		end
	end

	assign count_x = {5'd0, count_q};

	assign done = done_q;
	assign ok = ok_q;
	assign out_id = id_q;
	assign out_payload = pay_q;
	assign entry_count = count_x[4:0];
	assign is_empty = empty;

endmodule

[sim/tb_record_deque_with_search.sv]
// Self-checking testbench for the record deque: push, pop, read by position and find by id.
`timescale 1ns / 1ps

module tb_record_deque_with_search;
	import rdq_pkg::*;

	// Codes 6 and 7 are not assigned to any operation.
	localparam logic [2:0] FN_SPARE_LOW = 3'd6;
	localparam logic [2:0] FN_SPARE_HIGH = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = CAPACITY + 8;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] id;
		logic [63:0]        payload;
		logic [4:0]         count;
		logic               empty;
	} deque_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         func = FN_PUSH_BACK;
	logic signed [31:0] position = '0;
	logic signed [31:0] record_id = '0;
	logic [63:0]        record_payload = '0;
	logic               done;
	logic               ok;
	logic signed [31:0] out_id;
	logic [63:0]        out_payload;
	logic [4:0]         entry_count;
	logic               is_empty;

	// Shadow copy of the deque, updated when a transaction is accepted.
	logic signed [31:0] shadow_ids [CAPACITY];
	logic [63:0]        shadow_payloads [CAPACITY];
	int unsigned        shadow_head = 0;
	int unsigned        shadow_count = 0;

	deque_answer_t pending_answers [$];
	int unsigned   mismatches = 0;
	int unsigned   cycle_count = 0;
	int            sender_idle_pct = 0;

	record_deque_with_search DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.position       (position),
		.record_id      (record_id),
		.record_payload (record_payload),
		.done           (done),
		.ok             (ok),
		.out_id         (out_id),
		.out_payload    (out_payload),
		.entry_count    (entry_count),
		.is_empty       (is_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic deque_answer_t predict_answer(input logic [2:0] f, input logic [31:0] pos,
			input logic signed [31:0] key, input logic [63:0] pay);
		deque_answer_t answer;
		int unsigned   slot;
		int unsigned   k;
		answer = '0;
		case (f)
			FN_PUSH_BACK: begin
				if (shadow_count < CAPACITY) begin
					slot = (shadow_head + shadow_count) % CAPACITY;
					shadow_ids[slot] = key;
					shadow_payloads[slot] = pay;
					shadow_count++;
					answer.ok = 1'b1;
				end
			end
			FN_PUSH_FRONT: begin
				if (shadow_count < CAPACITY) begin
					shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
					shadow_ids[shadow_head] = key;
					shadow_payloads[shadow_head] = pay;
					shadow_count++;
					answer.ok = 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (shadow_count > 0) begin
					shadow_count--;
					answer.ok = 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (shadow_count > 0) begin
					shadow_head = (shadow_head + 1) % CAPACITY;
					shadow_count--;
					answer.ok = 1'b1;
				end
			end
			FN_READ_POS: begin
				// The position is compared unsigned, so negative values are out of range.
				if (pos >= 1 && pos <= shadow_count) begin
					slot = (shadow_head + pos - 1) % CAPACITY;
					answer.id = shadow_ids[slot];
					answer.payload = shadow_payloads[slot];
					answer.ok = 1'b1;
				end
			end
			FN_FIND_ID: begin
				for (k = 0; k < shadow_count && !answer.ok; k++) begin
					slot = (shadow_head + k) % CAPACITY;
					if (shadow_ids[slot] == key) begin
						answer.id = shadow_ids[slot];
						answer.payload = shadow_payloads[slot];
						answer.ok = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		answer.count = 5'(shadow_count);
		answer.empty = (shadow_count == 0);
		return answer;
	endfunction

	// Results are checked before the new transaction is queued, so a result can never
	// be matched against the request accepted at the same edge.
	always @(posedge clk) begin
		deque_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: cycle %0d result with no transaction pending", cycle_count);
			end else begin
				want = pending_answers.pop_front();
				if (ok !== want.ok || out_id !== want.id || out_payload !== want.payload ||
						entry_count !== want.count || is_empty !== want.empty) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: cycle %0d expected ok=%0b id=%0d payload=%h count=%0d empty=%0b",
							cycle_count, want.ok, want.id, want.payload, want.count, want.empty);
						$display("       got ok=%0b id=%0d payload=%h count=%0d empty=%0b",
							ok, out_id, out_payload, entry_count, is_empty);
					end
				end
			end
		end
		if (arst_n && start && !busy)
			pending_answers.push_back(predict_answer(func, position, record_id,
				record_payload));
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("record_deque_with_search verification failed");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] f, input logic signed [31:0] pos,
			input logic signed [31:0] key, input logic [63:0] pay);
		int gap;
		start <= 1'b1;
		func <= f;
		position <= pos;
		record_id <= key;
		record_payload <= pay;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_queue();
		sender_idle_pct = 0;
		send_request(FN_POP_BACK, $urandom, $urandom, {$urandom, $urandom});
		send_request(FN_POP_FRONT, $urandom, $urandom, {$urandom, $urandom});
		send_request(FN_READ_POS, 32'sd1, $urandom, {$urandom, $urandom});
		send_request(FN_FIND_ID, $urandom, 32'sd0, {$urandom, $urandom});
		send_request(FN_SPARE_LOW, 32'sd1, $urandom, {$urandom, $urandom});
	endtask

	task automatic test_full_queue_limits();
		int i;
		sender_idle_pct = 0;
		send_request(FN_PUSH_BACK, 32'sd0, 32'sh7FFF_FFFF, '1);
		send_request(FN_PUSH_BACK, 32'sd0, 32'sh8000_0000, '0);
		send_request(FN_PUSH_FRONT, 32'sd0, -32'sd1, 64'hA5A5_5A5A_0F0F_F0F0);
		send_request(FN_PUSH_FRONT, 32'sd0, 32'sd0, 64'h8000_0000_0000_0001);
		// Several records share id 7 so that find must return the one nearest the head.
		for (i = 4; i < CAPACITY; i++)
			send_request(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, $urandom,
				(i % 3 == 0) ? 32'sd7 : $urandom, {$urandom, $urandom});
		send_request(FN_PUSH_BACK, $urandom, 32'sd99, {$urandom, $urandom});
		send_request(FN_PUSH_FRONT, $urandom, 32'sd99, {$urandom, $urandom});
		send_request(FN_READ_POS, 32'sd0, $urandom, {$urandom, $urandom});
		send_request(FN_READ_POS, 32'(CAPACITY), $urandom, {$urandom, $urandom});
		send_request(FN_READ_POS, 32'(CAPACITY + 1), $urandom, {$urandom, $urandom});
		send_request(FN_READ_POS, 32'sh8000_0000, $urandom, {$urandom, $urandom});
		send_request(FN_FIND_ID, $urandom, 32'sd7, {$urandom, $urandom});
		send_request(FN_FIND_ID, $urandom, 32'sh8000_0000, {$urandom, $urandom});
		send_request(FN_POP_BACK, $urandom, $urandom, {$urandom, $urandom});
		send_request(FN_POP_FRONT, $urandom, $urandom, {$urandom, $urandom});
	endtask

	task automatic test_pause_until_idle();
		sender_idle_pct = 0;
		send_request(FN_PUSH_BACK, $urandom, 32'sd12345, {$urandom, $urandom});
		send_request(FN_FIND_ID, $urandom, 32'sd12345, {$urandom, $urandom});
		wait_until_drained();
		send_request(FN_READ_POS, 32'sd1, $urandom, {$urandom, $urandom});
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct);
		int          n;
		int          pick;
		bit          filling;
		logic [2:0]  f;
		logic [31:0] pos;
		logic [31:0] key;
		sender_idle_pct = idle_pct;
		filling = 1'b1;
		for (n = 0; n < items; n++) begin
			// Alternate between filling and draining so both ends of the ring get exercised.
			if (shadow_count >= CAPACITY)
				filling = 1'b0;
			else if (shadow_count == 0)
				filling = 1'b1;
			else if ($urandom_range(99) < 3)
				filling = !filling;
			pick = $urandom_range(99);
			if (pick >= 98)
				f = pick[0] ? FN_SPARE_HIGH : FN_SPARE_LOW;
			else if (filling)
				f = (pick < 30) ? FN_PUSH_BACK : (pick < 50) ? FN_PUSH_FRONT :
					(pick < 60) ? FN_POP_BACK : (pick < 70) ? FN_POP_FRONT :
					(pick < 85) ? FN_READ_POS : FN_FIND_ID;
			else
				f = (pick < 15) ? FN_PUSH_BACK : (pick < 25) ? FN_PUSH_FRONT :
					(pick < 45) ? FN_POP_BACK : (pick < 65) ? FN_POP_FRONT :
					(pick < 82) ? FN_READ_POS : FN_FIND_ID;
			pos = ($urandom_range(99) < 80) ? 32'($urandom_range(shadow_count + 1)) : $urandom;
			pick = $urandom_range(99);
			if (f == FN_FIND_ID && shadow_count > 0 && pick < 60)
				key = shadow_ids[(shadow_head + $urandom_range(shadow_count - 1)) % CAPACITY];
			else if (pick < 80)
				key = 32'($urandom_range(7)) - 32'd4;
			else
				key = $urandom;
			send_request(f, pos, key, {$urandom, $urandom});
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_full_queue_limits();
		test_pause_until_idle();
		test_random_traffic(140, 0);
		test_random_traffic(130, 61);
		wait_until_drained();
		test_random_traffic(130, 22);
		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("record_deque_with_search verification clean");
		else
			$display("record_deque_with_search verification failed");
		$finish;
	end

endmodule
